FILE: src/pulse_peak_bpm_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Pulse peak tracker assertion macros
// Clocked concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef PULSE_PEAK_BPM_TRACKER_CORE_DEFINES_SVH
`define PULSE_PEAK_BPM_TRACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked every clock edge outside reset
`define PPBT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// Condition in one cycle implies a property in the next
`define PPBT_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define PPBT_ASSERT(label, prop, msg)
`define PPBT_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

FILE: src/ppbt_pkg.sv
// ----------------------------------------------------------------------------
// Pulse peak tracker package
// Field widths, default register values, divider constants and state types.
// ----------------------------------------------------------------------------
package ppbt_pkg;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int TIME_W   = 32;
   localparam int LEVEL_W  = 23;
   localparam int RATE_W   = 16;

   // Configuration port
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // Defaults
   localparam int WINDOW_DEF = 10;
   localparam logic [LEVEL_W-1:0] RESET_LEVEL_DEF = LEVEL_W'(2000);
   localparam logic [LEVEL_W-1:0] START_LEVEL_DEF = LEVEL_W'(100);

   // 60000 milliseconds per minute, scaled by 16 for a Q12.4 beat rate
   localparam logic [TIME_W-1:0] RATE_NUM = TIME_W'(960000);

   // Shared divider: quotient register width and step counts
   localparam int QUO_W      = 20;
   localparam int STEP_W     = 5;
   localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(QUO_W);
   localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(RATE_W);

   // Register index codes
   typedef enum logic {
      REG_RESET_LEVEL = 1'b0,
      REG_START_LEVEL = 1'b1
   } reg_index_type;

   // Waveform phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RISE = 2'd1,
      PH_FALL = 2'd2
   } phase_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_STORE,
      ST_SUM,
      ST_AVG_PREP,
      ST_AVG_DONE,
      ST_EMIT
   } ctrl_type;

endpackage

FILE: src/ppbt_if.sv
// ----------------------------------------------------------------------------
// Pulse peak tracker channels
// Valid/ready channels for sample transactions and result transactions.
// ----------------------------------------------------------------------------
interface ppbt_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ppbt_pkg::SAMPLE_W-1:0]  sample;
   logic        [ppbt_pkg::TIME_W-1:0]    time_ms;

   modport source (output valid, output sample, output time_ms, input ready);
   modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface ppbt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            pulse_found;
   logic [ppbt_pkg::RATE_W-1:0]     bpm_average;
   logic [ppbt_pkg::LEVEL_W-1:0]    peak_level;

   modport source (output valid, output pulse_found, output bpm_average,
                   output peak_level, input ready);
   modport sink   (input valid, input pulse_found, input bpm_average,
                   input peak_level, output ready);
endinterface

FILE: src/pulse_peak_bpm_tracker_core.sv
// ----------------------------------------------------------------------------
// Pulse peak and beat-rate tracker
// Follows an optical pulse waveform, reports beat peaks and keeps a running
// average of the beat rate over a ring of recent beats.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one sample transaction (sample, time_ms); rsp_chan returns
//   exactly one result transaction (pulse_found, bpm_average, peak_level) for
//   each. reset_level and start_level are written over the APB port, registers
//   at byte addresses 0 and 4; the user must write them only while no
//   transaction is in flight, as the block itself does not enforce this.
//   A sample that does not complete a beat goes straight to the emit state,
//   which loads its result; the next sample is taken once that result is loaded.
//   A sample that completes a beat runs the shared one-bit-per-cycle divider
//   for the rate (20 steps), sweeps the rate ring one entry per cycle
//   (WINDOW steps), then divides again for the average (16 steps) before its
//   result is loaded; no new sample is accepted until then.
//   A result waits in the output register while rsp_chan.ready is low; one
//   more sample may be accepted meanwhile, and its result holds until the
//   register frees up.
//   Synchronous reset returns the detector to idle, clears all timing state,
//   empties the ring and restores the register defaults.
// ----------------------------------------------------------------------------
`include "pulse_peak_bpm_tracker_core_defines.svh"

module pulse_peak_bpm_tracker_core #(
   parameter int WINDOW = ppbt_pkg::WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ppbt_req_if.sink                       req_chan,
   ppbt_rsp_if.source                     rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ppbt_pkg::ADDR_W-1:0]    paddr,
   input  logic [ppbt_pkg::DATA_W-1:0]    pwdata,
   output logic [ppbt_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = ppbt_pkg::RATE_W + FILL_W;
   localparam int QW     = ppbt_pkg::QUO_W;
   localparam int TW     = ppbt_pkg::TIME_W;
   localparam int RW     = ppbt_pkg::RATE_W;
   localparam int LW     = ppbt_pkg::LEVEL_W;
   localparam int SW     = ppbt_pkg::SAMPLE_W;

   // Configuration registers
   logic [LW-1:0] reset_level_ff;
   logic [LW-1:0] start_level_ff;

   // Sequencer
   ppbt_pkg::ctrl_type state_ff;
   ppbt_pkg::ctrl_type state_in;

   // Detector state
   ppbt_pkg::phase_type  phase_ff;
   logic signed [SW-1:0] prev_ff;
   logic [TW-1:0]        peak_time_ff;
   logic [TW-1:0]        last_peak_time_ff;
   logic [LW-1:0]        peak_value_ff;
   logic                 pulse_ff;

   // Rate ring and average
   logic [RW-1:0]     ring_ff [WINDOW];
   logic [SLOT_W-1:0] ring_slot_ff;
   logic [FILL_W-1:0] ring_filled_ff;
   logic [RW-1:0]     average_ff;
   logic [SLOT_W-1:0] sweep_idx_ff;
   logic [SUM_W-1:0]  sum_ff;

   // Shared restoring divider
   logic [TW-1:0]                div_ff;
   logic [TW-1:0]                rem_ff;
   logic [QW-1:0]                quo_ff;
   logic [ppbt_pkg::STEP_W-1:0]  step_ff;
   logic                         div_avg_ff;
   logic                         zero_div_ff;

   // Result register
   logic          rsp_valid_ff;
   logic          rsp_pulse_ff;
   logic [RW-1:0] rsp_avg_ff;
   logic [LW-1:0] rsp_peak_ff;

   // Combinational terms
   logic                 accept;
   logic                 out_free;
   logic                 emit_load;
   logic                 over_reset;
   logic                 rising;
   logic                 at_start;
   logic                 beat_now;
   logic                 div_last;
   logic                 sweep_last;
   logic [TW:0]          trial;
   logic [TW:0]          diff;
   logic                 fits;
   logic [TW-1:0]        rate_numer;
   logic [SUM_W-1:0]     avg_numer;
   logic [RW-1:0]        rate_val;
   logic [RW-1:0]        sweep_val;
   ppbt_pkg::reg_index_type csr_index;

   // Configuration port
   assign pready    = 1'b1;
   assign csr_index = ppbt_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      case (csr_index)
         ppbt_pkg::REG_RESET_LEVEL: prdata = ppbt_pkg::DATA_W'(reset_level_ff);
         ppbt_pkg::REG_START_LEVEL: prdata = ppbt_pkg::DATA_W'(start_level_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_level_ff <= ppbt_pkg::RESET_LEVEL_DEF;
         start_level_ff <= ppbt_pkg::START_LEVEL_DEF;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            ppbt_pkg::REG_RESET_LEVEL: reset_level_ff <= pwdata[LW-1:0];
            ppbt_pkg::REG_START_LEVEL: start_level_ff <= pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // Sample decisions
   assign over_reset = req_chan.sample > $signed({1'b0, reset_level_ff});
   assign rising     = req_chan.sample > prev_ff;
   assign at_start   = req_chan.sample >= $signed({1'b0, start_level_ff});
   assign beat_now   = !over_reset && (phase_ff == ppbt_pkg::PH_RISE) && !rising;

   // Divider step: shift in one numerator bit, subtract when it fits
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign fits     = !diff[TW];
   assign div_last = (step_ff == ((div_avg_ff ? ppbt_pkg::AVG_STEPS : ppbt_pkg::RATE_STEPS)
                                  - ppbt_pkg::STEP_W'(1)));

   // Rounded numerators
   assign rate_numer = ppbt_pkg::RATE_NUM + {1'b0, div_ff[TW-1:1]};
   assign avg_numer  = sum_ff + SUM_W'(ring_filled_ff >> 1);

   // Saturated rate, zero for a zero interval
   always_comb begin
      if (zero_div_ff) begin
         rate_val = '0;
      end else if (|quo_ff[QW-1:RW]) begin
         rate_val = '1;
      end else begin
         rate_val = quo_ff[RW-1:0];
      end
   end

   // Ring entries past the fill count read as zero
   assign sweep_val  = (FILL_W'(sweep_idx_ff) < ring_filled_ff) ? ring_ff[sweep_idx_ff] : '0;
   assign sweep_last = (sweep_idx_ff == SLOT_W'(WINDOW - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppbt_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = beat_now ? ppbt_pkg::ST_PREP : ppbt_pkg::ST_EMIT;
            end
         end
         ppbt_pkg::ST_PREP:     state_in = ppbt_pkg::ST_DIV;
         ppbt_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = div_avg_ff ? ppbt_pkg::ST_AVG_DONE : ppbt_pkg::ST_STORE;
            end
         end
         ppbt_pkg::ST_STORE:    state_in = ppbt_pkg::ST_SUM;
         ppbt_pkg::ST_SUM: begin
            if (sweep_last) begin
               state_in = ppbt_pkg::ST_AVG_PREP;
            end
         end
         ppbt_pkg::ST_AVG_PREP: state_in = ppbt_pkg::ST_DIV;
         ppbt_pkg::ST_AVG_DONE: state_in = ppbt_pkg::ST_EMIT;
         ppbt_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = ppbt_pkg::ST_IDLE;
            end
         end
         default:               state_in = ppbt_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs: hold off input transactions during reset
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      req_chan.ready = !reset && (state_ff == ppbt_pkg::ST_IDLE);
      accept         = req_chan.valid && !reset && (state_ff == ppbt_pkg::ST_IDLE);
      emit_load      = out_free && (state_ff == ppbt_pkg::ST_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppbt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Detector, ring and divider datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= ppbt_pkg::PH_IDLE;
         prev_ff           <= '0;
         peak_time_ff      <= '0;
         last_peak_time_ff <= '0;
         peak_value_ff     <= '0;
         pulse_ff          <= 1'b0;
         ring_slot_ff      <= '0;
         ring_filled_ff    <= '0;
         average_ff        <= '0;
         sweep_idx_ff      <= '0;
         step_ff           <= '0;
         div_avg_ff        <= 1'b0;
      end else begin
         case (state_ff)
            ppbt_pkg::ST_IDLE: begin
               if (accept) begin
                  pulse_ff <= 1'b0;
                  if (over_reset) begin
                     // Clear the detector, keep the ring
                     phase_ff          <= ppbt_pkg::PH_IDLE;
                     prev_ff           <= '0;
                     peak_time_ff      <= '0;
                     last_peak_time_ff <= '0;
                     peak_value_ff     <= '0;
                  end else if (phase_ff == ppbt_pkg::PH_RISE) begin
                     if (rising) begin
                        peak_time_ff  <= req_chan.time_ms;
                        peak_value_ff <= req_chan.sample[SW-1] ? '0 : req_chan.sample[LW-1:0];
                        prev_ff       <= req_chan.sample;
                     end else begin
                        // Beat: hold the previous sample, start the rate divide
                        div_ff            <= peak_time_ff - last_peak_time_ff;
                        last_peak_time_ff <= peak_time_ff;
                        phase_ff          <= ppbt_pkg::PH_FALL;
                        pulse_ff          <= 1'b1;
                     end
                  end else if (phase_ff == ppbt_pkg::PH_FALL) begin
                     if (!at_start) begin
                        phase_ff <= ppbt_pkg::PH_IDLE;
                     end
                     prev_ff <= req_chan.sample;
                  end else begin
                     phase_ff <= at_start ? ppbt_pkg::PH_RISE : ppbt_pkg::PH_IDLE;
                     prev_ff  <= req_chan.sample;
                  end
               end
            end
            ppbt_pkg::ST_PREP: begin
               // Quotient fits in QUO_W bits, so start with the top numerator bits
               zero_div_ff <= (div_ff == '0);
               rem_ff      <= TW'(rate_numer[TW-1:QW]);
               quo_ff      <= rate_numer[QW-1:0];
               step_ff     <= '0;
               div_avg_ff  <= 1'b0;
            end
            ppbt_pkg::ST_DIV: begin
               rem_ff  <= fits ? diff[TW-1:0] : trial[TW-1:0];
               quo_ff  <= {quo_ff[QW-2:0], fits};
               step_ff <= step_ff + ppbt_pkg::STEP_W'(1);
            end
            ppbt_pkg::ST_STORE: begin
               ring_ff[ring_slot_ff] <= rate_val;
               ring_slot_ff <= (ring_slot_ff == SLOT_W'(WINDOW - 1)) ? '0
                               : ring_slot_ff + SLOT_W'(1);
               if (ring_filled_ff != FILL_W'(WINDOW)) begin
                  ring_filled_ff <= ring_filled_ff + FILL_W'(1);
               end
               sweep_idx_ff <= '0;
               sum_ff       <= '0;
            end
            ppbt_pkg::ST_SUM: begin
               // Accumulate one ring entry per cycle
               sum_ff       <= sum_ff + SUM_W'(sweep_val);
               sweep_idx_ff <= sweep_idx_ff + SLOT_W'(1);
            end
            ppbt_pkg::ST_AVG_PREP: begin
               div_ff     <= TW'(ring_filled_ff);
               rem_ff     <= TW'(avg_numer[SUM_W-1:RW]);
               quo_ff     <= {avg_numer[RW-1:0], (QW-RW)'(0)};
               step_ff    <= '0;
               div_avg_ff <= 1'b1;
            end
            ppbt_pkg::ST_AVG_DONE: begin
               average_ff <= quo_ff[RW-1:0];
            end
            default: ;
         endcase
      end
   end

   // Result register: load when empty or drained this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_pulse_ff <= pulse_ff;
         rsp_avg_ff   <= average_ff;
         rsp_peak_ff  <= peak_value_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pulse_found = rsp_pulse_ff;
   assign rsp_chan.bpm_average = rsp_avg_ff;
   assign rsp_chan.peak_level  = rsp_peak_ff;

   // Assertions
   `PPBT_ASSERT(a_fill_bound, ring_filled_ff <= FILL_W'(WINDOW), "ring fill count overran")
   `PPBT_ASSERT(a_slot_bound, FILL_W'(ring_slot_ff) < FILL_W'(WINDOW), "ring slot out of range")
   `PPBT_ASSERT(a_rem_below, ((state_ff == ppbt_pkg::ST_DIV) && (div_ff != '0)) |-> (rem_ff < div_ff), "divider remainder not below divisor")
   `PPBT_ASSERT(a_pulse_fall, ((state_ff == ppbt_pkg::ST_EMIT) && pulse_ff) |-> (phase_ff == ppbt_pkg::PH_FALL), "beat reported outside falling phase")
   `PPBT_ASSERT_NEXT(a_store_fill, state_ff == ppbt_pkg::ST_STORE, (ring_filled_ff != '0) && (ring_filled_ff >= $past(ring_filled_ff)), "ring fill count did not advance")

endmodule
